FILE: hdl/polygon_edge_clipper_core_macros.svh
// Assertion macros used by the polygon clipper controller
`ifndef POLYGON_EDGE_CLIPPER_CORE_MACROS_SVH
`define POLYGON_EDGE_CLIPPER_CORE_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define PEC_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pec assertion failed");

// next-cycle implication
`define PEC_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pec assertion failed");

`endif

FILE: hdl/pec_pkg.sv
// Shared types and constants of the polygon edge clipper
package pec_pkg;

   localparam int WORD_BITS      = 24;
   localparam int MAX_WORDS      = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int COUNT_BITS     = 8;
   localparam int QUOT_BITS      = 16;
   localparam int STEP_BITS      = 4;
   localparam int SHIFT_BITS     = 4;
   localparam int LEN_BITS       = 4;

   // fraction precisions
   localparam int FRAC_2D = 15;
   localparam int PREC_2D = 14;
   localparam int HALF_2D = 7;
   localparam int PREC_NZ = 8;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE       = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLIP_MIN   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLIP_MAX   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEAR_PLANE = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ATTR_COUNT = 3'd4;

   // reset values of the registers
   localparam logic signed [WORD_BITS-1:0] CLIP_MIN_RESET   = 24'sd0;
   localparam logic signed [WORD_BITS-1:0] CLIP_MAX_RESET   = 24'sd319;
   localparam logic signed [WORD_BITS-1:0] NEAR_PLANE_RESET = 24'sd1;
   localparam logic [2:0]                  ATTR_COUNT_RESET = 3'd2;

   // clip modes
   localparam logic [1:0] MODE_X    = 2'd0;
   localparam logic [1:0] MODE_Y    = 2'd1;
   localparam logic [1:0] MODE_NEAR = 2'd2;

   // boundary selects
   localparam logic [1:0] BND_MIN  = 2'd0;
   localparam logic [1:0] BND_MAX  = 2'd1;
   localparam logic [1:0] BND_NEAR = 2'd2;

   // output register sources
   localparam logic [1:0] OUT_CUR   = 2'd0;
   localparam logic [1:0] OUT_WORK  = 2'd1;
   localparam logic [1:0] OUT_WRAP  = 2'd2;
   localparam logic [1:0] OUT_EMPTY = 2'd3;

   // what one edge produces: entry vertex, then current or exit vertex
   typedef struct packed {
      logic       vp_emit;
      logic [1:0] vp_bound;
      logic       vc_emit;
      logic       vc_interp;
      logic [1:0] vc_bound;
   } plan_type;

   typedef struct packed {
      logic       load_in;
      logic       clear_count;
      logic       div_start;
      logic       mul_issue;
      logic       out_load;
      logic [1:0] out_sel;
      logic [1:0] bound_sel;
      logic       save_prev;
   } cmd_type;

   typedef struct packed {
      logic     start;
      logic     close;
      plan_type plan;
      logic     div_busy;
      logic     out_free;
      logic     count_zero;
   } status_type;

endpackage

FILE: hdl/pec_div.sv
// Serial restoring divider for the interpolation fraction
module pec_div import pec_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] num,
   input  logic [WORD_BITS-1:0] den,
   input  logic [STEP_BITS-1:0] steps,
   output logic                 busy,
   output logic [QUOT_BITS-1:0] quot
);

   localparam int REM_BITS = WORD_BITS + 2;

   logic                 busy_ff, busy_in;
   logic [STEP_BITS:0]   cnt_ff, cnt_in;
   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [QUOT_BITS-1:0] quot_ff, quot_in;
   logic [REM_BITS-1:0]  den_ext, rem_sub;
   logic                 ge;

   assign den_ext = REM_BITS'(den);
   assign ge      = rem_ff >= den_ext;
   assign rem_sub = ge ? rem_ff - den_ext : rem_ff;

   // one quotient bit per cycle, steps+1 bits in all
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = {1'b0, steps} + 1'b1;
         rem_in  = REM_BITS'(num);
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = {rem_sub[REM_BITS-2:0], 1'b0};
         quot_in = {quot_ff[QUOT_BITS-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != (STEP_BITS+1)'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule

FILE: hdl/pec_dpath.sv
// Datapath: registers, vertex stores, edge tests, interpolation and result register
module pec_dpath import pec_pkg::*; #(
   parameter int VERTEX_WORDS = 8,
   parameter int COORD_BITS   = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0]         csr_index,
   input  logic [WORD_BITS-1:0]              csr_wdata,
   input  logic signed [WORD_BITS-1:0]       in_words [VERTEX_WORDS],
   input  logic                              in_start,
   input  logic                              in_close,
   input  cmd_type                           cmd,
   input  logic [$clog2(VERTEX_WORDS)-1:0]   mul_word,
   output status_type                        status,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic signed [WORD_BITS-1:0]       out_words [VERTEX_WORDS],
   output logic                              out_wrap,
   output logic                              out_empty,
   output logic                              out_final,
   output logic [COUNT_BITS-1:0]             out_total
);

   localparam int WIDX      = $clog2(VERTEX_WORDS);
   localparam int DIFF_BITS = WORD_BITS + 1;
   localparam int PROD_BITS = QUOT_BITS + 1 + DIFF_BITS;
   localparam int SUM_BITS  = PROD_BITS + 2;
   localparam int WRAP_SH   = SUM_BITS - COORD_BITS;

   // configuration
   logic [1:0]                  mode_ff, mode_in;
   logic signed [WORD_BITS-1:0] clip_min_ff, clip_min_in;
   logic signed [WORD_BITS-1:0] clip_max_ff, clip_max_in;
   logic signed [WORD_BITS-1:0] near_ff, near_in;
   logic [2:0]                  attr_count_ff, attr_count_in;

   // vertex stores
   logic signed [WORD_BITS-1:0] cur_ff [VERTEX_WORDS], cur_in [VERTEX_WORDS];
   logic signed [WORD_BITS-1:0] prev_ff [VERTEX_WORDS], prev_in [VERTEX_WORDS];
   logic signed [WORD_BITS-1:0] first_ff [VERTEX_WORDS], first_in [VERTEX_WORDS];
   logic signed [WORD_BITS-1:0] work_ff [VERTEX_WORDS], work_in [VERTEX_WORDS];
   logic                        start_ff, start_in, close_ff, close_in;
   logic [COUNT_BITS-1:0]       count_ff, count_in;

   // multiply stage
   logic                        a_valid_ff, a_valid_in;
   logic [WIDX-1:0]             a_idx_ff, a_idx_in;
   logic signed [WORD_BITS-1:0] a_base_ff, a_base_in;
   logic signed [PROD_BITS-1:0] a_prod_ff, a_prod_in;
   logic [SHIFT_BITS-1:0]       a_sh_ff, a_sh_in;

   // result register
   logic                        out_valid_ff, out_valid_in;
   logic signed [WORD_BITS-1:0] out_w_ff [VERTEX_WORDS], out_w_in [VERTEX_WORDS];
   logic                        out_wrap_ff, out_wrap_in;
   logic                        out_empty_ff, out_empty_in;
   logic                        out_final_ff, out_final_in;
   logic [COUNT_BITS-1:0]       out_total_ff, out_total_in;

   logic signed [WORD_BITS-1:0] prev_c, cur_c, lo_c, hi_c, bound_val;
   logic                        prev_low;
   plan_type                    plan;
   logic signed [DIFF_BITS-1:0] num_d, den_d;
   logic [WORD_BITS-1:0]        div_num, div_den;
   logic [STEP_BITS-1:0]        div_steps;
   logic                        div_busy;
   logic [QUOT_BITS-1:0]        quot;
   logic signed [WORD_BITS-1:0] lk, rk;
   logic signed [DIFF_BITS-1:0] dk, dd;
   logic [QUOT_BITS-1:0]        m;
   logic signed [QUOT_BITS:0]   m_s;
   logic signed [SUM_BITS-1:0]  sum_b, wrap_tmp, wrap_val;
   logic [LEN_BITS-1:0]         len_raw, len;
   logic                        out_free, vertex_load;
   logic [COUNT_BITS-1:0]       count_next;

   // edge classification on the clip coordinate
   always_comb begin
      unique case (mode_ff)
         MODE_X: begin
            prev_c = prev_ff[0];
            cur_c  = cur_ff[0];
         end
         MODE_Y: begin
            prev_c = prev_ff[1];
            cur_c  = cur_ff[1];
         end
         default: begin
            prev_c = prev_ff[2];
            cur_c  = cur_ff[2];
         end
      endcase
      prev_low = prev_c < cur_c;
      lo_c     = prev_low ? prev_c : cur_c;
      hi_c     = prev_low ? cur_c : prev_c;
   end

   always_comb begin
      plan = '0;
      unique case (mode_ff)
         MODE_X, MODE_Y: begin
            if (!(lo_c >= clip_max_ff || hi_c <= clip_min_ff)) begin
               plan.vp_emit   = prev_low ? (lo_c <= clip_min_ff) : (hi_c >= clip_max_ff);
               plan.vp_bound  = prev_low ? BND_MIN : BND_MAX;
               plan.vc_emit   = 1'b1;
               plan.vc_interp = prev_low ? (hi_c >= clip_max_ff) : (lo_c <= clip_min_ff);
               plan.vc_bound  = prev_low ? BND_MAX : BND_MIN;
            end
         end
         MODE_NEAR: begin
            if (hi_c >= near_ff) begin
               plan.vp_emit   = prev_low && (lo_c < near_ff);
               plan.vp_bound  = BND_NEAR;
               plan.vc_emit   = 1'b1;
               plan.vc_interp = !prev_low && (lo_c < near_ff);
               plan.vc_bound  = BND_NEAR;
            end
         end
         default: begin
            // unused mode passes the vertex through
            plan.vc_emit = 1'b1;
         end
      endcase
   end

   // divider operands: (bound - L) / (R - L)
   always_comb begin
      unique case (cmd.bound_sel)
         BND_MIN: bound_val = clip_min_ff;
         BND_MAX: bound_val = clip_max_ff;
         default: bound_val = near_ff;
      endcase
      num_d     = DIFF_BITS'(bound_val) - DIFF_BITS'(lo_c);
      den_d     = DIFF_BITS'(hi_c) - DIFF_BITS'(lo_c);
      div_num   = num_d[DIFF_BITS-1] ? '0 : num_d[WORD_BITS-1:0];
      div_den   = (den_d[DIFF_BITS-1] || den_d == '0) ? WORD_BITS'(1) : den_d[WORD_BITS-1:0];
      div_steps = (mode_ff == MODE_NEAR) ? STEP_BITS'(PREC_NZ) : STEP_BITS'(FRAC_2D);
   end

   pec_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .steps (div_steps),
      .busy  (div_busy),
      .quot  (quot)
   );

   // multiply stage: one vertex word per cycle
   always_comb begin
      lk        = prev_low ? prev_ff[mul_word] : cur_ff[mul_word];
      rk        = prev_low ? cur_ff[mul_word] : prev_ff[mul_word];
      dk        = DIFF_BITS'(rk) - DIFF_BITS'(lk);
      m         = quot;
      dd        = dk;
      a_sh_in   = SHIFT_BITS'(PREC_NZ);
      a_base_in = lk;
      if (mode_ff == MODE_NEAR) begin
         if (mul_word == WIDX'(2)) begin
            a_base_in = bound_val;
            m         = '0;
            a_sh_in   = '0;
         end
      end else if (mul_word == WIDX'(mode_ff[0])) begin
         a_base_in = bound_val;
         m         = '0;
         a_sh_in   = '0;
      end else if (mul_word == WIDX'(!mode_ff[0])) begin
         m       = quot >> (FRAC_2D - PREC_2D);
         a_sh_in = SHIFT_BITS'(PREC_2D);
      end else if (mul_word == WIDX'(2)) begin
         a_sh_in = SHIFT_BITS'(FRAC_2D);
      end else begin
         m       = quot >> (FRAC_2D - PREC_2D + HALF_2D);
         dd      = dk >>> HALF_2D;
         a_sh_in = '0;
      end
      m_s        = $signed({1'b0, m});
      a_prod_in  = PROD_BITS'(m_s) * PROD_BITS'(dd);
      a_valid_in = cmd.mul_issue;
      a_idx_in   = mul_word;
   end

   // add stage and wrap to the coordinate width
   always_comb begin
      sum_b    = SUM_BITS'(a_base_ff) + SUM_BITS'(a_prod_ff >>> a_sh_ff);
      wrap_tmp = sum_b <<< WRAP_SH;
      wrap_val = wrap_tmp >>> WRAP_SH;
   end

   // words in use
   always_comb begin
      len_raw = LEN_BITS'(attr_count_ff) + LEN_BITS'(3);
      len     = (len_raw > LEN_BITS'(VERTEX_WORDS)) ? LEN_BITS'(VERTEX_WORDS) : len_raw;
   end

   assign out_free    = !out_valid_ff || !rsp_stall;
   assign vertex_load = cmd.out_load && (cmd.out_sel == OUT_CUR || cmd.out_sel == OUT_WORK);
   assign count_next  = (count_ff == '1) ? count_ff : count_ff + 1'b1;

   // next state of all registers
   always_comb begin
      mode_in       = mode_ff;
      clip_min_in   = clip_min_ff;
      clip_max_in   = clip_max_ff;
      near_in       = near_ff;
      attr_count_in = attr_count_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      first_in      = first_ff;
      work_in       = work_ff;
      start_in      = start_ff;
      close_in      = close_ff;
      count_in      = count_ff;
      out_w_in      = out_w_ff;
      out_wrap_in   = out_wrap_ff;
      out_empty_in  = out_empty_ff;
      out_final_in  = out_final_ff;
      out_total_in  = out_total_ff;
      out_valid_in  = out_valid_ff && rsp_stall;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_MODE:       mode_in       = csr_wdata[1:0];
            CSR_CLIP_MIN:   clip_min_in   = $signed(csr_wdata);
            CSR_CLIP_MAX:   clip_max_in   = $signed(csr_wdata);
            CSR_NEAR_PLANE: near_in       = $signed(csr_wdata);
            CSR_ATTR_COUNT: attr_count_in = csr_wdata[2:0];
            default: ;
         endcase
      end

      if (cmd.load_in) begin
         cur_in   = in_words;
         start_in = in_start;
         close_in = in_close;
      end
      if (cmd.save_prev) begin
         prev_in = cur_ff;
      end
      if (a_valid_ff) begin
         work_in[a_idx_ff] = wrap_val[WORD_BITS-1:0];
      end
      if (cmd.clear_count) begin
         count_in = '0;
      end

      // result register load
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
         unique case (cmd.out_sel)
            OUT_CUR, OUT_WORK: begin
               for (int j = 0; j < VERTEX_WORDS; j++) begin
                  if (LEN_BITS'(j) < len) begin
                     out_w_in[j] = (cmd.out_sel == OUT_WORK) ? work_ff[j] : cur_ff[j];
                  end else begin
                     out_w_in[j] = '0;
                  end
               end
               out_wrap_in  = 1'b0;
               out_empty_in = 1'b0;
               out_final_in = 1'b0;
               out_total_in = count_next;
            end
            OUT_WRAP: begin
               out_w_in     = first_ff;
               out_wrap_in  = 1'b1;
               out_empty_in = 1'b0;
               out_final_in = 1'b1;
               out_total_in = count_ff;
            end
            default: begin
               for (int j = 0; j < VERTEX_WORDS; j++) begin
                  out_w_in[j] = '0;
               end
               out_wrap_in  = 1'b0;
               out_empty_in = 1'b1;
               out_final_in = 1'b1;
               out_total_in = '0;
            end
         endcase
      end
      if (vertex_load) begin
         count_in = count_next;
         if (count_ff == '0) begin
            first_in = out_w_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_X;
         clip_min_ff   <= CLIP_MIN_RESET;
         clip_max_ff   <= CLIP_MAX_RESET;
         near_ff       <= NEAR_PLANE_RESET;
         attr_count_ff <= ATTR_COUNT_RESET;
         for (int i = 0; i < VERTEX_WORDS; i++) begin
            prev_ff[i] <= '0;
         end
         count_ff      <= '0;
         a_valid_ff    <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         clip_min_ff   <= clip_min_in;
         clip_max_ff   <= clip_max_in;
         near_ff       <= near_in;
         attr_count_ff <= attr_count_in;
         prev_ff       <= prev_in;
         count_ff      <= count_in;
         a_valid_ff    <= a_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      cur_ff       <= cur_in;
      first_ff     <= first_in;
      work_ff      <= work_in;
      start_ff     <= start_in;
      close_ff     <= close_in;
      a_idx_ff     <= a_idx_in;
      a_base_ff    <= a_base_in;
      a_prod_ff    <= a_prod_in;
      a_sh_ff      <= a_sh_in;
      out_w_ff     <= out_w_in;
      out_wrap_ff  <= out_wrap_in;
      out_empty_ff <= out_empty_in;
      out_final_ff <= out_final_in;
      out_total_ff <= out_total_in;
   end

   always_comb begin
      status.start      = start_ff;
      status.close      = close_ff;
      status.plan       = plan;
      status.div_busy   = div_busy;
      status.out_free   = out_free;
      status.count_zero = (count_ff == '0);
   end

   assign rsp_valid = out_valid_ff;
   assign out_words = out_w_ff;
   assign out_wrap  = out_wrap_ff;
   assign out_empty = out_empty_ff;
   assign out_final = out_final_ff;
   assign out_total = out_total_ff;

endmodule

FILE: hdl/pec_ctrl.sv
// Controller: sequences edge evaluation, division, interpolation and result loads
`include "polygon_edge_clipper_core_macros.svh"
module pec_ctrl import pec_pkg::*; #(
   parameter int VERTEX_WORDS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   output cmd_type                         cmd,
   output logic [$clog2(VERTEX_WORDS)-1:0] mul_word,
   input  status_type                      status
);

   localparam int WIDX = $clog2(VERTEX_WORDS);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EVAL  = 3'd1;
   localparam logic [2:0] S_SLOT  = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_MUL   = 3'd4;
   localparam logic [2:0] S_DRAIN = 3'd5;
   localparam logic [2:0] S_EMIT  = 3'd6;
   localparam logic [2:0] S_CLOSE = 3'd7;

   logic [2:0]      state_ff, state_in;
   logic            have_prev_ff, have_prev_in;
   logic            phase_ff, phase_in;
   plan_type        plan_ff, plan_in;
   logic [WIDX-1:0] word_ff, word_in;
   logic            slot_emit, slot_interp;

   // phase 0 is the entry vertex, phase 1 the current or exit vertex
   assign slot_emit   = phase_ff ? plan_ff.vc_emit : plan_ff.vp_emit;
   assign slot_interp = phase_ff ? plan_ff.vc_interp : 1'b1;

   always_comb begin
      state_in      = state_ff;
      have_prev_in  = have_prev_ff;
      phase_in      = phase_ff;
      plan_in       = plan_ff;
      word_in       = word_ff;
      cmd           = '0;
      cmd.bound_sel = phase_ff ? plan_ff.vc_bound : plan_ff.vp_bound;
      cmd.out_sel   = OUT_CUR;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            if (status.start || !have_prev_ff) begin
               cmd.clear_count = 1'b1;
               have_prev_in    = 1'b1;
               state_in        = S_CLOSE;
            end else begin
               plan_in  = status.plan;
               phase_in = 1'b0;
               state_in = S_SLOT;
            end
         end
         S_SLOT: begin
            if (!slot_emit) begin
               if (phase_ff) begin
                  state_in = S_CLOSE;
               end else begin
                  phase_in = 1'b1;
               end
            end else if (slot_interp) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_DIV: begin
            if (!status.div_busy) begin
               word_in  = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_issue = 1'b1;
            if (word_ff == WIDX'(VERTEX_WORDS - 1)) begin
               state_in = S_DRAIN;
            end else begin
               word_in = word_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            cmd.out_sel = slot_interp ? OUT_WORK : OUT_CUR;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (phase_ff) begin
                  state_in = S_CLOSE;
               end else begin
                  phase_in = 1'b1;
                  state_in = S_SLOT;
               end
            end
         end
         default: begin
            // closing vertex adds the wrap copy or the empty flag
            cmd.out_sel = status.count_zero ? OUT_EMPTY : OUT_WRAP;
            if (!status.close) begin
               cmd.save_prev = 1'b1;
               state_in      = S_IDLE;
            end else if (status.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.save_prev = 1'b1;
               have_prev_in  = 1'b0;
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         have_prev_ff <= 1'b0;
         phase_ff     <= 1'b0;
         plan_ff      <= '0;
         word_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         have_prev_ff <= have_prev_in;
         phase_ff     <= phase_in;
         plan_ff      <= plan_in;
         word_ff      <= word_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign mul_word  = word_ff;

   `PEC_ASSERT_IMPL(a_load_free, cmd.out_load, status.out_free)
   `PEC_ASSERT_NEXT(a_accept_eval, req_valid && (state_ff == S_IDLE), state_ff == S_EVAL)
   `PEC_ASSERT_IMPL(a_div_idle, cmd.div_start, !status.div_busy)
   `PEC_ASSERT_IMPL(a_mul_after_div, cmd.mul_issue, !status.div_busy)

endmodule

FILE: hdl/polygon_edge_clipper_core.sv
// Polygon edge clipper: one boundary, one vertex per request.
// Requests (req_*) carry a vertex and start/close marks; results (rsp_*) carry
// clipped vertices, the wrap copy of the first output, or an empty flag.
// Registers are written through csr_write_en/csr_index/csr_wdata; the user must
// write them only while idle, as the block does not enforce it. Each request
// yields 0 to 3 results. A request is taken only when the block is idle, so
// req_stall is high from acceptance until the request is done. A vertex that
// opens a polygon passes through the idle, evaluate and close states; an edge
// passes the slot state for its entry and then its exit or end vertex before
// close, with a result load for each vertex it yields. Each intersection adds
// a serial divider run and a pass of all VERTEX_WORDS words through the shared
// multiplier and its drain state before the result load.
// A result waits in the output register while rsp_stall is high; the block holds
// in its load state only while it has a further result to load.
// Reset clears the registers to their defaults, the previous vertex to zero and
// the valid flag of the output register; the next vertex starts a new polygon.
module polygon_edge_clipper_core import pec_pkg::*; #(
   parameter int VERTEX_WORDS = 8,
   parameter int COORD_BITS   = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [WORD_BITS-1:0]        csr_wdata,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [WORD_BITS-1:0] req_pos_x,
   input  logic signed [WORD_BITS-1:0] req_pos_y,
   input  logic signed [WORD_BITS-1:0] req_pos_z,
   input  logic signed [WORD_BITS-1:0] req_attr_a,
   input  logic signed [WORD_BITS-1:0] req_attr_b,
   input  logic signed [WORD_BITS-1:0] req_attr_c,
   input  logic signed [WORD_BITS-1:0] req_attr_d,
   input  logic signed [WORD_BITS-1:0] req_attr_e,
   input  logic                        req_starts_polygon,
   input  logic                        req_closes_polygon,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [WORD_BITS-1:0] rsp_out_x,
   output logic signed [WORD_BITS-1:0] rsp_out_y,
   output logic signed [WORD_BITS-1:0] rsp_out_z,
   output logic signed [WORD_BITS-1:0] rsp_out_a,
   output logic signed [WORD_BITS-1:0] rsp_out_b,
   output logic signed [WORD_BITS-1:0] rsp_out_c,
   output logic signed [WORD_BITS-1:0] rsp_out_d,
   output logic signed [WORD_BITS-1:0] rsp_out_e,
   output logic                        rsp_is_wrap_copy,
   output logic                        rsp_polygon_empty,
   output logic                        rsp_final_result,
   output logic [COUNT_BITS-1:0]       rsp_vertex_total
);

   logic signed [WORD_BITS-1:0]     all_in [MAX_WORDS];
   logic signed [WORD_BITS-1:0]     all_out [MAX_WORDS];
   logic signed [WORD_BITS-1:0]     in_words [VERTEX_WORDS];
   logic signed [WORD_BITS-1:0]     out_words [VERTEX_WORDS];
   cmd_type                         cmd;
   status_type                      status;
   logic [$clog2(VERTEX_WORDS)-1:0] mul_word;

   assign all_in[0] = req_pos_x;
   assign all_in[1] = req_pos_y;
   assign all_in[2] = req_pos_z;
   assign all_in[3] = req_attr_a;
   assign all_in[4] = req_attr_b;
   assign all_in[5] = req_attr_c;
   assign all_in[6] = req_attr_d;
   assign all_in[7] = req_attr_e;

   // words beyond the configured vertex size read as zero
   for (genvar i = 0; i < MAX_WORDS; i++) begin : g_words
      if (i < VERTEX_WORDS) begin : g_used
         assign in_words[i] = all_in[i];
         assign all_out[i]  = out_words[i];
      end else begin : g_unused
         assign all_out[i] = '0;
      end
   end

   assign rsp_out_x = all_out[0];
   assign rsp_out_y = all_out[1];
   assign rsp_out_z = all_out[2];
   assign rsp_out_a = all_out[3];
   assign rsp_out_b = all_out[4];
   assign rsp_out_c = all_out[5];
   assign rsp_out_d = all_out[6];
   assign rsp_out_e = all_out[7];

   pec_ctrl #(
      .VERTEX_WORDS (VERTEX_WORDS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .mul_word  (mul_word),
      .status    (status)
   );

   pec_dpath #(
      .VERTEX_WORDS (VERTEX_WORDS),
      .COORD_BITS   (COORD_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .in_words     (in_words),
      .in_start     (req_starts_polygon),
      .in_close     (req_closes_polygon),
      .cmd          (cmd),
      .mul_word     (mul_word),
      .status       (status),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .out_words    (out_words),
      .out_wrap     (rsp_is_wrap_copy),
      .out_empty    (rsp_polygon_empty),
      .out_final    (rsp_final_result),
      .out_total    (rsp_vertex_total)
   );

endmodule
